>>> design/swf_pkg.sv
// swf_pkg: types and constants shared by the sawtooth voice with fade
// request/result structs, control enums, serial multiplier geometry
`timescale 1ns / 1ps

package swf_pkg;

  localparam int unsigned MUL_A_W   = 40;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_STEPS = MUL_B_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS + 1);

  localparam logic [23:0] ONE_SAMPLE = 24'h001000;
  localparam logic [23:0] PHASE_MAX  = 24'hFFFFFF;
  localparam logic [24:0] Q24_ONE    = 25'h1000000;
  localparam logic [14:0] SAMPLE_MAX = 15'h7FFF;

  typedef struct packed {
    logic        start_req;
    logic        channel;
    logic [14:0] amplitude;
    logic [23:0] period_q;
    logic [23:0] step_q;
  } swf_in_t;

  typedef struct packed {
    logic [14:0] sample;
    logic        too_high;
  } swf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } swf_state_e;

  typedef enum logic [1:0] {
    OP_FADE,
    OP_RATIO,
    OP_AMP,
    OP_SCALE
  } swf_op_e;

endpackage

>>> design/sawtooth_voice_with_fade.sv
// sawtooth_voice_with_fade: one request at a time, accepted again only after the result
// has been registered for output; each request runs four 8-step products on the
// shared radix-16 serial multiplier (fade, phase ratio, amplitude, envelope)
// async active-low reset clears phases, position, inverse_length and handshakes
// depends on swf_pkg and swf_mul
`timescale 1ns / 1ps

module sawtooth_voice_with_fade import swf_pkg::*; #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [24:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  swf_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output swf_out_t    out_data_o
);

  swf_state_e state_q, state_d;
  swf_op_e    op_q, op_next;

  swf_in_t     in_q;
  logic [24:0] inv_len_q;
  logic [23:0] phase_q [CHANNELS];
  logic [31:0] position_q;
  logic [31:0] pos_use_q;
  logic [23:0] phase_new_q;
  logic [24:0] fade_q;
  logic [38:0] acc_q;
  logic [14:0] sample_q;
  swf_out_t    out_q;
  logic        out_valid_q;

  logic               ch_valid;
  logic [23:0]        phase_rd;
  logic [23:0]        phase_old;
  logic [24:0]        phase_sum;
  logic [23:0]        phase_sat;
  logic [23:0]        phase_new;
  logic [31:0]        pos_old;
  logic               silent;
  logic               out_free;
  logic               mul_start;
  logic               mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  assign ch_valid = (32'(in_q.channel) < CHANNELS);

  always_comb begin
    phase_rd = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(in_q.channel) == i) begin
        phase_rd = phase_q[i];
      end
    end
  end

  // advance one sample, saturate, wrap once past the period
  assign phase_old = in_q.start_req ? '0 : phase_rd;
  assign phase_sum = {1'b0, phase_old} + {1'b0, ONE_SAMPLE};
  assign phase_sat = phase_sum[24] ? PHASE_MAX : phase_sum[23:0];
  assign phase_new = (in_q.period_q != '0 && phase_sat > in_q.period_q)
                   ? phase_sat - in_q.period_q : phase_sat;
  assign pos_old   = in_q.start_req ? '0 : position_q;

  assign silent   = !ch_valid || (in_q.period_q == '0) || in_q.step_q[23];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (op_q)
      OP_FADE: begin
        mul_a = MUL_A_W'(inv_len_q);
        mul_b = pos_use_q;
      end
      OP_RATIO: begin
        mul_a = MUL_A_W'(phase_new_q);
        mul_b = MUL_B_W'(in_q.step_q);
      end
      OP_AMP: begin
        mul_a = MUL_A_W'(acc_q[23:0]);
        mul_b = MUL_B_W'(in_q.amplitude);
      end
      OP_SCALE: begin
        mul_a = MUL_A_W'(acc_q);
        mul_b = MUL_B_W'(fade_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (op_q)
      OP_FADE:  op_next = OP_RATIO;
      OP_RATIO: op_next = OP_AMP;
      OP_AMP:   op_next = OP_SCALE;
      default:  op_next = OP_FADE;
    endcase
  end

  swf_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .done_o   (mul_done),
    .prod_o   (mul_p)
  );

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mul_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_PHASE;
        end
      end
      ST_PHASE: begin
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_d = (op_q == OP_SCALE) ? ST_FINISH : ST_ISSUE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_FADE;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PHASE) begin
        op_q <= OP_FADE;
      end else if (state_q == ST_WAIT && mul_done) begin
        op_q <= op_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_len_q  <= '0;
      position_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        inv_len_q <= cfg_data_i;
      end
      if (state_q == ST_PHASE) begin
        position_q <= (pos_old == '1) ? pos_old : pos_old + 32'd1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_valid && 32'(in_q.channel) == i) begin
            phase_q[i] <= phase_new;
          end else if (in_q.start_req) begin
            phase_q[i] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == ST_PHASE) begin
      pos_use_q   <= pos_old;
      phase_new_q <= phase_new;
    end
    if (state_q == ST_WAIT && mul_done) begin
      case (op_q)
        OP_FADE: begin
          fade_q <= (mul_p[56:24] == '0) ? Q24_ONE - {1'b0, mul_p[23:0]} : '0;
        end
        OP_RATIO: begin
          acc_q <= 39'(mul_p[47:24]);
        end
        OP_AMP: begin
          acc_q <= mul_p[38:0];
        end
        OP_SCALE: begin
          if (silent) begin
            sample_q <= '0;
          end else if (mul_p[63:51] != '0) begin
            sample_q <= SAMPLE_MAX;
          end else begin
            sample_q <= mul_p[50:36];
          end
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
    if (state_q == ST_FINISH && out_free) begin
      out_q.sample   <= sample_q;
      out_q.too_high <= in_q.step_q[23];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/swf_mul.sv
// swf_mul: radix-16 shift-add multiplier, one multiplier digit per cycle
// depends on swf_pkg for operand widths and step count
`timescale 1ns / 1ps

module swf_mul import swf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] mcand_i,
  input  logic [MUL_B_W-1:0] mplier_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);

  localparam int unsigned SUM_W = MUL_A_W + DIGIT_W;

  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [MUL_A_W-1:0]   mcand_q;
  logic [MUL_P_W-1:0]   prod_q;
  logic [SUM_W-1:0]     partial;
  logic [SUM_W-1:0]     sum;

  // upper product bits plus multiplicand times low digit, then shift one digit
  assign partial = SUM_W'(mcand_q) * SUM_W'(prod_q[DIGIT_W-1:0]);
  assign sum     = SUM_W'(prod_q[MUL_P_W-1:MUL_B_W]) + partial;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = MUL_CNT_W'(MUL_STEPS);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      prod_q  <= {{MUL_A_W{1'b0}}, mplier_i};
    end else if (cnt_q != '0) begin
      prod_q <= {sum, prod_q[MUL_B_W-1:DIGIT_W]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

>>> design/swf_checker.sv
// swf_checker: port-level checks over time for sawtooth_voice_with_fade
// depends on swf_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module swf_checker import swf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input swf_out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // a new result only appears while the input side is busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in flight");

  // nyquist error silences the sample
  a_too_high_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_high |-> out_data_o.sample == '0)
    else $error("too_high result with nonzero sample");

endmodule

bind sawtooth_voice_with_fade swf_checker u_swf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> bench/tb.sv
// tb: self-checking bench for sawtooth_voice_with_fade, with a directed table, a short
// silent-note phase run and random note segments under several fade rates
// depends on swf_pkg and the design sources
`timescale 1ns / 1ps

module tb;
  import swf_pkg::*;

  localparam int unsigned LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SWEEP_LEN = 40;
  localparam int unsigned PHASE_REQS = 75;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [24:0] cfg_val;
    swf_in_t     req;
    logic        typed;
    swf_out_t    want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [27] = '{
    '{ROW_REQ, 25'd0, '{1'b1, 1'b0, 15'h7FFF, 24'h000000, 24'h400000}, 1'b1, '{15'd0, 1'b0}},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h7FFF, 24'h002000, 24'h7FFFFF}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h7FFF, 24'h001000, 24'h800000}, 1'b1, '{15'd0, 1'b1}},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h0000, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, '{15'd0, 1'b1}},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h0000, 24'h010000, 24'h100000}, 1'b1, '{15'd0, 1'b0}},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h7FFF, 24'hFFFFFF, 24'h7FFFFF}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h0001, 24'h000001, 24'h000001}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h5555, 24'hAAAAAA, 24'h555555}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h2AAA, 24'h555555, 24'h2AAAAA}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b1, 1'b1, 15'h4000, 24'h004000, 24'h040000}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h4000, 24'h004000, 24'h040000}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h4000, 24'h004000, 24'h040000}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h4000, 24'h004000, 24'h040000}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h4000, 24'h004000, 24'h040000}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h7FFF, 24'h000800, 24'h7FFFFF}, 1'b0, '0},
    '{ROW_CFG, 25'h1000000, '0, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b1, 1'b0, 15'h7FFF, 24'h008000, 24'h200000}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h7FFF, 24'h008000, 24'h200000}, 1'b1, '{15'd0, 1'b0}},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h7FFF, 24'h008000, 24'h200000}, 1'b1, '{15'd0, 1'b0}},
    '{ROW_CFG, 25'h1FFFFFF, '0, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b1, 1'b1, 15'h7FFF, 24'h003000, 24'h155555}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b1, 15'h7FFF, 24'h003000, 24'h155555}, 1'b1, '{15'd0, 1'b0}},
    '{ROW_CFG, 25'h0400000, '0, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b1, 1'b0, 15'h7FFF, 24'h003000, 24'h155555}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h7FFF, 24'h003000, 24'h155555}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h7FFF, 24'h003000, 24'h155555}, 1'b0, '0},
    '{ROW_REQ, 25'd0, '{1'b0, 1'b0, 15'h7FFF, 24'h003000, 24'h155555}, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [24:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  swf_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  swf_out_t    out_data_o;

  // predictor state
  logic [23:0] saw_phase [2] = '{default: '0};
  logic [31:0] seg_position = '0;
  logic [24:0] fade_rate = '0;

  swf_out_t pending_samples [$];

  bit no_gaps = 1'b0;
  bit long_hold = 1'b0;
  int unsigned cycles = 0;
  int unsigned bad_results = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;
  int unsigned n_nyquist = 0;
  int unsigned n_clipped = 0;
  int unsigned n_silent = 0;

  sawtooth_voice_with_fade i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic swf_out_t next_voice_sample(input swf_in_t req);
    swf_out_t    res;
    logic [56:0] frac;
    logic [24:0] fade;
    logic [24:0] ph;
    logic [47:0] ramp;
    logic [63:0] prod;
    res = '0;
    res.too_high = req.step_q[23];
    if (req.start_req) begin
      saw_phase[0] = '0;
      saw_phase[1] = '0;
      seg_position = '0;
    end
    frac = 57'(seg_position) * 57'(fade_rate);
    fade = (frac >= 57'(Q24_ONE)) ? 25'd0 : 25'(57'(Q24_ONE) - frac);
    ph = 25'(saw_phase[req.channel]) + 25'(ONE_SAMPLE);
    if (ph > 25'(PHASE_MAX)) ph = 25'(PHASE_MAX);
    if (req.period_q != '0 && ph > 25'(req.period_q)) ph = ph - 25'(req.period_q);
    saw_phase[req.channel] = ph[23:0];
    if (req.period_q != '0 && !res.too_high) begin
      ramp = 48'(ph) * 48'(req.step_q);
      prod = 64'(ramp[47:24]) * 64'(req.amplitude) * 64'(fade);
      res.sample = (prod[63:36] > 28'(SAMPLE_MAX)) ? SAMPLE_MAX : prod[50:36];
    end
    if (seg_position != '1) seg_position++;
    return res;
  endfunction

  function automatic logic [23:0] pick_period();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 24'($urandom);
      2: return 24'($urandom_range(1, 24'h3000));
      default: return 24'($urandom_range(2 * 4096, 400 * 4096));
    endcase
  endfunction

  function automatic logic [23:0] pick_step(input logic [23:0] period);
    longint unsigned base;
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return 24'h800000 + 24'($urandom_range(0, 255));
      2: return 24'h7FFFFF - 24'($urandom_range(0, 255));
      default: begin
        if (period == '0) return 24'($urandom_range(0, 24'h7FFFFF));
        base = (64'd1 << 36) / period * $urandom_range(50, 150) / 100;
        return (base > 64'h7FFFFF) ? 24'h7FFFFF : 24'(base);
      end
    endcase
  endfunction

  function automatic logic [14:0] pick_amp();
    return ($urandom_range(0, 3) == 0) ? 15'h7FFF : 15'($urandom);
  endfunction

  task automatic send_req(input swf_in_t req, input bit typed, input swf_out_t want);
    int gap;
    swf_out_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pred = next_voice_sample(req);
    pending_samples.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_fade_rate(input logic [24:0] rate);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= rate;
    do @(posedge clk_i); while (!cfg_ready_o);
    fade_rate = rate;
    n_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // note segments: a start request, then both channels with mostly steady notes
  task automatic play_segments(input int n_req);
    int left;
    int seg_len;
    logic ch;
    logic [23:0] per [2];
    logic [23:0] stp [2];
    logic [14:0] amp [2];
    swf_in_t req;
    left = n_req;
    while (left > 0) begin
      seg_len = $urandom_range(4, 60);
      for (int c = 0; c < 2; c++) begin
        per[c] = pick_period();
        stp[c] = pick_step(per[c]);
        amp[c] = pick_amp();
      end
      ch = 1'($urandom_range(0, 1));
      for (int k = 0; k < seg_len && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          req.start_req = 1'($urandom_range(0, 1));
          req.channel = 1'($urandom_range(0, 1));
          req.amplitude = 15'($urandom);
          req.period_q = 24'($urandom);
          req.step_q = 24'($urandom);
        end else begin
          if ($urandom_range(0, 15) == 0) begin
            per[ch] = pick_period();
            stp[ch] = pick_step(per[ch]);
            amp[ch] = pick_amp();
          end
          req.start_req = (k == 0);
          req.channel = ch;
          req.amplitude = amp[ch];
          req.period_q = per[ch];
          req.step_q = stp[ch];
        end
        send_req(req, 1'b0, '0);
        left--;
        if ($urandom_range(0, 3) != 0) ch = ~ch;
      end
    end
  endtask

  // receiver with random back pressure
  initial begin
    int wait_n;
    wait (rst_ni);
    forever begin
      wait_n = no_gaps ? 0 : $urandom_range(0, 16);
      if (long_hold) begin
        wait_n = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      @(negedge clk_i);
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    swf_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (out_data_o.too_high) n_nyquist++;
      if (out_data_o.sample == SAMPLE_MAX) n_clipped++;
      if (out_data_o.sample == '0) n_silent++;
      if (pending_samples.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: sample %0d too_high %0b",
                   out_data_o.sample, out_data_o.too_high);
      end else begin
        want = pending_samples.pop_front();
        if (want.sample !== out_data_o.sample || want.too_high !== out_data_o.too_high) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch at result %0d: sample exp %0d got %0d, too_high exp %0b got %0b",
                     n_checked, want.sample, out_data_o.sample,
                     want.too_high, out_data_o.too_high);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_samples.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [24:0] rates [$];
    swf_in_t req;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) set_fade_rate(DIR_TAB[i].cfg_val);
      else send_req(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // silent note on the left channel builds up its phase, then wide and narrow periods
    set_fade_rate('0);
    no_gaps = 1'b1;
    for (int i = 0; i < SWEEP_LEN + 3; i++) begin
      req.start_req = (i == 0);
      req.channel = 1'b0;
      req.amplitude = (i < SWEEP_LEN) ? 15'($urandom) : 15'h7FFF;
      req.step_q = (i < SWEEP_LEN) ? 24'($urandom_range(0, 24'h7FFFFF)) : 24'h000100;
      case (i - SWEEP_LEN)
        0: req.period_q = 24'hFFFFFF;
        1: req.period_q = 24'hFFFFFE;
        2: req.period_q = 24'h001000;
        default: req.period_q = '0;
      endcase
      send_req(req, 1'b0, '0);
    end
    no_gaps = 1'b0;

    rates = '{25'h1000000, 25'd1, 25'h1FFFFFF, 25'd0};
    repeat (3) rates.push_back(25'(25'h1000000 / $urandom_range(8, 80)));
    rates.push_back(25'($urandom));
    foreach (rates[i]) begin
      set_fade_rate(rates[i]);
      no_gaps = (i == 3 || i == 5);
      if (i == 5) long_hold = 1'b1;
      play_segments(PHASE_REQS);
    end
    no_gaps = 1'b0;

    drain_results();
    repeat (60) @(posedge clk_i);
    $display("%0d requests over %0d fade rate settings, %0d results checked",
             n_sent, n_settings, n_checked);
    $display("%0d at or above nyquist, %0d clipped to full scale, %0d silent",
             n_nyquist, n_clipped, n_silent);
    if (bad_results == 0 && pending_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d bad results, %0d never arrived", bad_results, pending_samples.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/swf_pkg.sv
design/swf_mul.sv
design/sawtooth_voice_with_fade.sv
design/swf_checker.sv
bench/tb.sv
